// ===== sv/fct_pkg.sv =====
// Shared types, constants and helpers for the MAC forwarding table.
package fct_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W        = 3;
  localparam int MAC_W       = 48;
  localparam int PORT_W      = 16;
  localparam int VLAN_W      = 12;
  localparam int STATUS_W    = 2;
  localparam int OUT_CNT_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_LEARN      = 3'd0,
    OP_AGE        = 3'd1,
    OP_MOVE       = 3'd2,
    OP_FLUSH_PORT = 3'd3,
    OP_FLUSH_VLAN = 3'd4,
    OP_FLUSH_ALL  = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_AGE_WR = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  // Low OUT_CNT_W bits of the count, zero extended when the count is narrower.
  function automatic logic [OUT_CNT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
    logic [OUT_CNT_W+CNT_W-1:0] tmp;
    tmp = {{OUT_CNT_W{1'b0}}, cnt};
    return tmp[OUT_CNT_W-1:0];
  endfunction

endpackage

// ===== sv/fct_match.sv =====
// Entry compare: decides whether a stored entry hits the current event's key.
module fct_match (
  input  fct_pkg::opcode_t op,
  input  fct_pkg::entry_t  key,
  input  fct_pkg::entry_t  ent,
  output logic             hit
);
  import fct_pkg::*;

  logic mac_eq, port_eq, vlan_eq;

  assign mac_eq  = (ent.mac == key.mac);
  assign port_eq = (ent.port == key.port);
  assign vlan_eq = (ent.vlan == key.vlan);

  always_comb begin
    case (op)
      OP_LEARN, OP_AGE: hit = mac_eq && port_eq;
      OP_MOVE:          hit = mac_eq;
      OP_FLUSH_PORT:    hit = port_eq;
      OP_FLUSH_VLAN:    hit = vlan_eq;
      default:          hit = 1'b0;
    endcase
  end

endmodule

// ===== sv/mac_forwarding_table_unit.sv =====
// MAC forwarding table: packed entry store with a scan/compact sequencer.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid in_stall in_opcode in_mac     | event in
//           | in_port in_vlan                        |
//   out     | out_valid out_stall out_status         | result out
//           | out_entry_count                        |
//
// One event at a time. A scanning event ends its scan early on a hit (learn,
// age, move) or at once on an empty table; the scan reads one entry per cycle
// from the entry memory (one read, one write per cycle), compares it in the
// next cycle, and compacts in place for the flush events. The input reopens in
// the same cycle as the result is registered. Flush all and unknown codes go
// from idle straight to the response state, with no scan.
// Reset (rst_n low, synchronous) empties the table by clearing the count;
// memory contents are not touched. A stalled result sits in the output
// register while the next event is already taken and processed; that event
// then holds its result back until the register frees up.
module mac_forwarding_table_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fct_pkg::OP_W-1:0]        in_opcode,
  input  logic [fct_pkg::MAC_W-1:0]       in_mac,
  input  logic [fct_pkg::PORT_W-1:0]      in_port,
  input  logic [fct_pkg::VLAN_W-1:0]      in_vlan,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fct_pkg::STATUS_W-1:0]    out_status,
  output logic [fct_pkg::OUT_CNT_W-1:0]   out_entry_count
);
  import fct_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  // Entry memory: one write and one registered read per cycle.
  entry_t             mem [TABLE_DEPTH];
  entry_t             rdata_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;
  logic [IDX_W-1:0]   mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // Sequencer state
  state_t           state_r,   state_nxt;
  opcode_t          op_r,      op_nxt;
  entry_t           key_r,     key_nxt;
  logic [CNT_W-1:0] cnt_r,     cnt_nxt;    // valid entries
  logic [CNT_W-1:0] rd_idx_r,  rd_idx_nxt; // next read to issue
  logic [CNT_W-1:0] kept_r,    kept_nxt;   // compaction write pointer
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  status_t          status_r,  status_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0] out_count_r,  out_count_nxt;

  logic hit;
  logic scan_end;
  logic is_flush;

  fct_match u_match (
    .op  (op_r),
    .key (key_r),
    .ent (rdata_r),
    .hit (hit)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  assign scan_end = !cmp_vld_r && (rd_idx_r >= cnt_r);
  assign is_flush = (op_r == OP_FLUSH_PORT) || (op_r == OP_FLUSH_VLAN);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    kept_nxt      = kept_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_idx_nxt   = hit_idx_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we = 1'b0;
    mem_wa = kept_r[IDX_W-1:0];
    mem_wd = rdata_r;
    mem_ra = rd_idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = opcode_t'(in_opcode);
          key_nxt.mac  = in_mac;
          key_nxt.port = in_port;
          key_nxt.vlan = in_vlan;
          rd_idx_nxt   = '0;
          kept_nxt     = '0;
          status_nxt   = ST_DONE;
          case (opcode_t'(in_opcode))
            OP_LEARN, OP_AGE, OP_MOVE, OP_FLUSH_PORT, OP_FLUSH_VLAN: begin
              state_nxt = S_SCAN;
            end
            OP_FLUSH_ALL: begin
              cnt_nxt   = '0;
              state_nxt = S_RESP;
            end
            default: begin
              status_nxt = ST_NOMATCH;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue side
        if (rd_idx_r < cnt_r) begin
          rd_idx_nxt  = rd_idx_r + ONE_C;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        // compare side
        if (cmp_vld_r) begin
          if (is_flush) begin
            if (!hit) begin
              mem_we   = 1'b1;
              mem_wa   = kept_r[IDX_W-1:0];
              mem_wd   = rdata_r;
              kept_nxt = kept_r + ONE_C;
            end
          end else if (hit) begin
            cmp_vld_nxt = 1'b0;
            case (op_r)
              OP_LEARN: begin
                status_nxt = ST_DUP;
                state_nxt  = S_RESP;
              end
              OP_AGE: begin
                // fetch the last entry to fill the hole
                hit_idx_nxt = cmp_idx_r;
                mem_ra      = IDX_W'(cnt_r - ONE_C);
                state_nxt   = S_AGE_WR;
              end
              default: begin // move
                mem_we       = 1'b1;
                mem_wa       = cmp_idx_r;
                mem_wd.mac   = rdata_r.mac;
                mem_wd.port  = key_r.port;
                mem_wd.vlan  = rdata_r.vlan;
                state_nxt    = S_RESP;
              end
            endcase
          end
        end else if (scan_end) begin
          state_nxt = S_RESP;
          case (op_r)
            OP_LEARN: begin
              if (cnt_r >= DEPTH_C) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = cnt_r[IDX_W-1:0];
                mem_wd  = key_r;
                cnt_nxt = cnt_r + ONE_C;
              end
            end
            OP_FLUSH_PORT, OP_FLUSH_VLAN: begin
              cnt_nxt = kept_r;
            end
            default: begin
              status_nxt = ST_NOMATCH;
            end
          endcase
        end
      end

      S_AGE_WR: begin
        mem_we    = 1'b1;
        mem_wa    = hit_idx_r;
        mem_wd    = rdata_r;
        cnt_nxt   = cnt_r - ONE_C;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_out(cnt_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    rd_idx_r     <= rd_idx_nxt;
    kept_r       <= kept_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_idx_r    <= hit_idx_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Assertions
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count beyond table depth");

  a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && is_flush && cmp_vld_r |-> kept_r[IDX_W-1:0] <= cmp_idx_r)
    else $error("compaction write overtook the scan");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result beat without a finished event");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the MAC forwarding table: event stimulus and result scoreboard.
module tb;
  import fct_pkg::*;

  // Opcodes outside the defined set; the block answers them with a no-match status.
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam int RANDOM_EVENTS  = 108;
  localparam int HOLD_CYCLES    = 400;   // long output hold-off for the back-pressure test
  localparam int DRAIN_CYCLES   = 32;    // quiet time after the last result
  // One event can scan ~4100 entries; allow a hold-off plus two full scans, several times over.
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int MAX_REPORTS    = 40;    // mismatch lines printed; all are counted

  typedef struct {
    status_t               status;
    logic [OUT_CNT_W-1:0]  count;
  } fwd_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_opcode = '0;
  logic [MAC_W-1:0]      in_mac    = '0;
  logic [PORT_W-1:0]     in_port   = '0;
  logic [VLAN_W-1:0]     in_vlan   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [OUT_CNT_W-1:0]  out_entry_count;

  mac_forwarding_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_mac          (in_mac),
    .in_port         (in_port),
    .in_vlan         (in_vlan),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  // ---------------------------------------------------------------------------
  // Forwarding table predictor: packed, unordered entry list with a count.
  // Entries at or above fwd_count are stale and never looked at.
  // ---------------------------------------------------------------------------
  logic [MAC_W-1:0]  fwd_mac  [TABLE_DEPTH];
  logic [PORT_W-1:0] fwd_port [TABLE_DEPTH];
  logic [VLAN_W-1:0] fwd_vlan [TABLE_DEPTH];
  int                fwd_count = 0;
  int                peak_count = 0;

  fwd_result_t expected_results[$];   // oldest first

  int err_count       = 0;
  int events_sent     = 0;
  int results_checked = 0;

  function automatic fwd_result_t predict_event(input logic [OP_W-1:0]   op,
                                                input logic [MAC_W-1:0]  mac,
                                                input logic [PORT_W-1:0] port,
                                                input logic [VLAN_W-1:0] vlan);
    fwd_result_t res;
    int          hit;
    int          kept;
    logic        drop;
    res.status = ST_DONE;
    hit = -1;
    case (op)
      OP_LEARN: begin
        // Duplicate check wins over the full check.
        for (int i = 0; i < fwd_count; i++) begin
          if (fwd_port[i] == port && fwd_mac[i] == mac) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          res.status = ST_DUP;
        end else if (fwd_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          fwd_mac[fwd_count]  = mac;
          fwd_port[fwd_count] = port;
          fwd_vlan[fwd_count] = vlan;
          fwd_count++;
        end
      end
      OP_AGE: begin
        // First MAC+port hit is replaced by the last entry.
        for (int i = 0; i < fwd_count; i++) begin
          if (fwd_port[i] == port && fwd_mac[i] == mac) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) begin
          fwd_mac[hit]  = fwd_mac[fwd_count-1];
          fwd_port[hit] = fwd_port[fwd_count-1];
          fwd_vlan[hit] = fwd_vlan[fwd_count-1];
          fwd_count--;
        end else begin
          res.status = ST_NOMATCH;
        end
      end
      OP_MOVE: begin
        // MAC-only match; VLAN is kept.
        for (int i = 0; i < fwd_count; i++) begin
          if (fwd_mac[i] == mac) begin
            hit = i;
            break;
          end
        end
        if (hit >= 0) fwd_port[hit] = port;
        else          res.status = ST_NOMATCH;
      end
      OP_FLUSH_PORT, OP_FLUSH_VLAN: begin
        // Order-preserving compaction.
        kept = 0;
        for (int i = 0; i < fwd_count; i++) begin
          drop = (op == OP_FLUSH_PORT) ? (fwd_port[i] == port) : (fwd_vlan[i] == vlan);
          if (!drop) begin
            fwd_mac[kept]  = fwd_mac[i];
            fwd_port[kept] = fwd_port[i];
            fwd_vlan[kept] = fwd_vlan[i];
            kept++;
          end
        end
        fwd_count = kept;
      end
      OP_FLUSH_ALL: fwd_count = 0;
      default:      res.status = ST_NOMATCH;
    endcase
    if (fwd_count > peak_count) peak_count = fwd_count;
    res.count = OUT_CNT_W'(fwd_count);
    return res;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting. Printing is capped so a broken run stays readable.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("tb: MISMATCH result %0d: %s got %0d expected %0d",
               results_checked, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one beat per call. Bursts of random length separated by random gaps
  // when tx_gaps_on is set; otherwise in_valid stays high for back-to-back beats.
  // ---------------------------------------------------------------------------
  bit tx_gaps_on = 1'b0;
  int burst_left = 0;

  task automatic send_event(input logic [OP_W-1:0]   op,
                            input logic [MAC_W-1:0]  mac,
                            input logic [PORT_W-1:0] port,
                            input logic [VLAN_W-1:0] vlan);
    int gap;
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_mac    <= mac;
    in_port   <= port;
    in_vlan   <= vlan;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Beat taken at this edge: predict in acceptance order.
    expected_results.insert(expected_results.size(), predict_event(op, mac, port, vlan));
    events_sent++;
    if (tx_gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 6);
        gap = $urandom_range(1, 9);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and wait for every outstanding result. Always moves at least one
  // edge so a following send never lowers and raises valid in one step.
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs when rx_stall_on, plus a counted long hold-off
  // requested by bumping hold_req.
  // ---------------------------------------------------------------------------
  bit rx_stall_on = 1'b0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int run_left = 0;

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!rx_stall_on) begin
      out_stall <= 1'b0;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;       // keep current stall level
    end else begin
      out_stall <= $urandom_range(0, 1);
      run_left  <= $urandom_range(0, 5);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fwd_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat, status", out_status, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", out_entry_count, want.count);
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: consecutive cycles with no beat on either channel.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: watchdog expired, %0d results outstanding", expected_results.size());
        $display("** mac_forwarding_table_unit: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Learn into an empty table: field extremes, a duplicate, same MAC on another port.
  task automatic test_learn();
    send_event(OP_LEARN, '0, '0, '0);
    send_event(OP_LEARN, '1, '1, '1);
    send_event(OP_LEARN, '0, '0, 12'h005);          // duplicate, VLAN ignored
    send_event(OP_LEARN, '0, '1, 12'h001);          // same MAC, other port
  endtask

  // Age: a hit pulls the last entry into the hole; then two misses where only the MAC matches.
  task automatic test_age();
    send_event(OP_AGE, '0, '0, '0);
    send_event(OP_AGE, '0, '0, '0);
    send_event(OP_AGE, '1, '0, '0);                 // MAC hit, port miss
  endtask

  // Move by MAC only, a miss, then age under the new port to see it took.
  task automatic test_move();
    send_event(OP_MOVE, '1, 16'h1234, '0);
    send_event(OP_MOVE, 48'h0000_0000_0123, 16'h1234, '0);
    send_event(OP_AGE,  '1, 16'h1234, '0);
  endtask

  // Flushes: compaction with hits, with no hits, on an empty table; empty-table lookups.
  task automatic test_flush();
    send_event(OP_LEARN, 48'h0200_0000_0001, 16'd7, 12'd9);
    send_event(OP_LEARN, 48'h0200_0000_0002, 16'd8, 12'd9);
    send_event(OP_LEARN, 48'h0200_0000_0003, 16'd7, 12'd10);
    send_event(OP_FLUSH_PORT, '0, 16'd7, '0);
    send_event(OP_FLUSH_PORT, '0, 16'd7, '0);       // nothing left to remove
    send_event(OP_FLUSH_VLAN, '0, '0, 12'd9);
    send_event(OP_FLUSH_ALL,  '0, '0, '0);
    send_event(OP_FLUSH_ALL,  '0, '0, '0);
    send_event(OP_AGE,  48'h0200_0000_0001, 16'd8, '0);
    send_event(OP_MOVE, 48'h0200_0000_0001, 16'd8, '0);
  endtask

  task automatic test_unused_codes();
    send_event(OP_LEARN, 48'h0300_0000_0001, 16'd3, 12'd3);
    send_event(OP_UNUSED_6, 48'h0300_0000_0001, 16'd3, 12'd3);
    send_event(OP_UNUSED_7, '1, '1, '1);
  endtask

  // Receiver runs the long hold-off while the sender keeps offering beats:
  // one result parks in the output register, the next event completes, and the
  // input must stall until the hold-off ends.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 8; i++)
      send_event(OP_LEARN, {16'h0400, 32'(i)}, 16'(i), 12'(i));
    wait_drained();
    send_event(OP_FLUSH_ALL, '0, '0, '0);
    wait_drained();
  endtask

  // Mostly coherent traffic from small MAC/port/VLAN pools so learns, ages and
  // moves keep hitting; a slice of fully random noise. Idling mode rotates.
  task automatic test_random_traffic();
    logic [MAC_W-1:0]  mac_pool  [12];
    logic [PORT_W-1:0] port_pool [4];
    logic [VLAN_W-1:0] vlan_pool [4];
    logic [OP_W-1:0]   op;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic [VLAN_W-1:0] vlan;
    int                pick;
    foreach (mac_pool[i])  mac_pool[i]  = rand_mac();
    foreach (port_pool[i]) port_pool[i] = PORT_W'($urandom);
    foreach (vlan_pool[i]) vlan_pool[i] = VLAN_W'($urandom);
    mac_pool[0]  = '0;
    mac_pool[1]  = '1;
    port_pool[0] = '1;
    vlan_pool[0] = '0;
    vlan_pool[1] = '1;
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 27 == 0) begin
        // both idle, neither, sender only, receiver only
        tx_gaps_on  = ((n / 27) % 4 == 0) || ((n / 27) % 4 == 2);
        rx_stall_on <= ((n / 27) % 4 == 0) || ((n / 27) % 4 == 3);
      end
      mac  = mac_pool[$urandom_range(0, 11)];
      port = port_pool[$urandom_range(0, 3)];
      vlan = vlan_pool[$urandom_range(0, 3)];
      pick = $urandom_range(0, 99);
      if      (pick < 40) op = OP_LEARN;
      else if (pick < 58) op = OP_AGE;
      else if (pick < 72) op = OP_MOVE;
      else if (pick < 78) op = OP_FLUSH_PORT;
      else if (pick < 84) op = OP_FLUSH_VLAN;
      else if (pick < 87) op = OP_FLUSH_ALL;
      else if (pick < 90) op = $urandom_range(0, 1) ? OP_UNUSED_7 : OP_UNUSED_6;
      else begin
        op   = OP_W'($urandom_range(0, 7));
        mac  = rand_mac();
        port = PORT_W'($urandom);
        vlan = VLAN_W'($urandom);
      end
      send_event(op, mac, port, vlan);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with idling on both sides.
    tx_gaps_on = 1'b1;
    rx_stall_on <= 1'b1;
    test_learn();
    test_age();
    test_move();
    test_flush();
    test_unused_codes();
    wait_drained();

    test_backpressure();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never returned, count", 0, expected_results.size());

    $display("tb: %0d events sent, %0d result beats checked, peak occupancy %0d of %0d",
             events_sent, results_checked, peak_count, TABLE_DEPTH);
    $display("tb: every opcode incl. unused codes, duplicates, misses, flushes, long hold-off");
    if (err_count == 0) begin
      $display("** mac_forwarding_table_unit: PASSED **");
    end else begin
      $display("** mac_forwarding_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
